// File: rtl/tspf_pkg.sv
`default_nettype none

package tspf_pkg;

	// stream constants
	localparam logic [7:0] SYNC_MARK    = 8'h47;
	localparam logic [7:0] PKT_LEN      = 8'd188;
	localparam logic [7:0] PKT_LEN_LONG = 8'd192;
	localparam logic [7:0] LAST_OFFSET  = 8'd187;

	// header byte 3 flag bits
	localparam int PAYLOAD_FLAG_BIT = 4;
	localparam int ADAPT_FLAG_BIT   = 5;

	localparam int PID_W       = 13;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 13;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_PID   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PACKETS = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_SECTION_MODE = 2'd2;

	// where in the packet the parser stands
	typedef enum logic [2:0] {
		RGN_HEADER,
		RGN_ADAPT_LEN,
		RGN_ADAPT_SKIP,
		RGN_POINTER,
		RGN_POINTER_SKIP,
		RGN_PAYLOAD,
		RGN_DROP
	} region_t;

	typedef struct packed {
		logic [PID_W-1:0] target_pid;
		logic             long_packets;
		logic             section_mode;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] payload_byte;
		logic       first_of_packet;
		logic       unit_start;
		logic       last_of_packet;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/tspf_in_stage.sv
`default_nettype none

module tspf_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] stream_byte,
	input  wire logic       advance,
	output logic            s1_valid,
	output logic [7:0]      byte_s1
);
	import tspf_pkg::*;

	logic valid_s1;

	// hold the word while the parser cannot move it on
	assign in_stall = valid_s1 && !advance;
	assign s1_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= stream_byte;
		end
	end

endmodule

`default_nettype wire

// File: rtl/tspf_parser.sv
`default_nettype none

module tspf_parser (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire logic [7:0]      byte_s1,
	input  wire tspf_pkg::cfg_t  cfg,
	output tspf_pkg::result_t    res
);
	import tspf_pkg::*;

	logic             locked_q, locked_d;
	logic [7:0]       pos_q, pos_d;
	region_t          region_q, region_d;
	logic [7:0]       skip_q, skip_d;
	logic             err_q, err_d;
	logic             pusi_q, pusi_d;
	logic [PID_W-1:0] pid_q, pid_d;
	logic             first_q, first_d;

	logic [7:0] period;
	logic [8:0] pos_inc;
	logic [7:0] pos_wrap;
	region_t    after_adapt;
	logic       hdr_ok;
	logic       in_packet;

	assign period   = cfg.long_packets ? PKT_LEN_LONG : PKT_LEN;
	assign pos_inc  = {1'b0, pos_q} + 9'd1;
	assign pos_wrap = (pos_inc >= {1'b0, period}) ? 8'd0 : pos_inc[7:0];
	assign after_adapt = (pusi_q && cfg.section_mode) ? RGN_POINTER : RGN_PAYLOAD;
	assign hdr_ok   = !err_q && byte_s1[PAYLOAD_FLAG_BIT] && (pid_q == cfg.target_pid);
	assign in_packet = (pos_q != 8'd0) && (pos_q < PKT_LEN);

	// next state
	always_comb begin
		locked_d = locked_q;
		pos_d    = pos_q;
		region_d = region_q;
		skip_d   = skip_q;
		err_d    = err_q;
		pusi_d   = pusi_q;
		pid_d    = pid_q;
		first_d  = first_q;
		if (step) begin
			if (!locked_q) begin
				// hunting for the first sync byte
				if (byte_s1 == SYNC_MARK) begin
					locked_d = 1'b1;
					region_d = RGN_HEADER;
					err_d    = 1'b0;
					pusi_d   = 1'b0;
					pid_d    = '0;
					first_d  = 1'b0;
					skip_d   = 8'd0;
					pos_d    = 8'd1;
				end
			end else begin
				pos_d = pos_wrap;
				if (pos_q == 8'd0) begin
					err_d    = 1'b0;
					pusi_d   = 1'b0;
					pid_d    = '0;
					first_d  = 1'b0;
					skip_d   = 8'd0;
					region_d = (byte_s1 == SYNC_MARK) ? RGN_HEADER : RGN_DROP;
				end else if (pos_q < PKT_LEN) begin
					case (region_q)
						RGN_HEADER: begin
							if (pos_q == 8'd1) begin
								err_d  = byte_s1[7];
								pusi_d = byte_s1[6];
								pid_d  = {byte_s1[4:0], 8'd0};
							end else if (pos_q == 8'd2) begin
								pid_d = {pid_q[PID_W-1:8], byte_s1};
							end else if (pos_q == 8'd3) begin
								if (!hdr_ok) begin
									region_d = RGN_DROP;
								end else begin
									first_d  = 1'b1;
									region_d = byte_s1[ADAPT_FLAG_BIT] ? RGN_ADAPT_LEN
										: after_adapt;
								end
							end else begin
								region_d = RGN_DROP;
							end
						end
						RGN_ADAPT_LEN: begin
							skip_d   = byte_s1;
							region_d = (byte_s1 != 8'd0) ? RGN_ADAPT_SKIP : after_adapt;
						end
						RGN_ADAPT_SKIP: begin
							skip_d = skip_q - 8'd1;
							if (skip_q == 8'd1) begin
								region_d = after_adapt;
							end
						end
						RGN_POINTER: begin
							skip_d   = byte_s1;
							region_d = (byte_s1 != 8'd0) ? RGN_POINTER_SKIP : RGN_PAYLOAD;
						end
						RGN_POINTER_SKIP: begin
							skip_d = skip_q - 8'd1;
							if (skip_q == 8'd1) begin
								region_d = RGN_PAYLOAD;
							end
						end
						RGN_PAYLOAD: begin
							first_d = 1'b0;
						end
						default: begin
							region_d = RGN_DROP;
						end
					endcase
				end
			end
		end
	end

	// result word
	always_comb begin
		res.valid           = step && locked_q && in_packet && (region_q == RGN_PAYLOAD);
		res.payload_byte    = byte_s1;
		res.first_of_packet = first_q;
		res.unit_start      = pusi_q;
		res.last_of_packet  = (pos_q == LAST_OFFSET);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locked_q <= 1'b0;
			pos_q    <= 8'd0;
			region_q <= RGN_HEADER;
			skip_q   <= 8'd0;
			err_q    <= 1'b0;
			pusi_q   <= 1'b0;
			pid_q    <= '0;
			first_q  <= 1'b0;
		end else begin
			locked_q <= locked_d;
			pos_q    <= pos_d;
			region_q <= region_d;
			skip_q   <= skip_d;
			err_q    <= err_d;
			pusi_q   <= pusi_d;
			pid_q    <= pid_d;
			first_q  <= first_d;
		end
	end

	// offset never reaches the long period
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < PKT_LEN_LONG)
		else $error("packet offset out of range");

	// offset stays at zero until the first sync byte
	a_hunt_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!locked_q |-> pos_q == 8'd0)
		else $error("offset moved while hunting");

	// a result word only comes from a processed byte
	a_res_step: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> step && region_q == RGN_PAYLOAD)
		else $error("result without a processed byte");

	// the last payload offset is followed by trailer or packet start
	a_last_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		step && locked_q && pos_q == LAST_OFFSET |=> pos_q == PKT_LEN || pos_q == 8'd0)
		else $error("offset did not advance past last payload byte");

endmodule

`default_nettype wire

// File: rtl/tspf_out_stage.sv
`default_nettype none

module tspf_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s1_valid,
	input  wire tspf_pkg::result_t res,
	output logic                   advance,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [7:0]             payload_byte,
	output logic                   first_of_packet,
	output logic                   unit_start,
	output logic                   last_of_packet
);
	import tspf_pkg::*;

	logic valid_q;

	// register is free when empty or being taken this cycle
	assign advance   = !valid_q || !out_stall;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= s1_valid && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_valid && res.valid) begin
			payload_byte    <= res.payload_byte;
			first_of_packet <= res.first_of_packet;
			unit_start      <= res.unit_start;
			last_of_packet  <= res.last_of_packet;
		end
	end

endmodule

`default_nettype wire

// File: rtl/transport_stream_pid_filter_unit.sv
// Transport stream PID filter.
// Input channel: in_valid / in_stall with one stream byte per word. Output
// channel: out_valid / out_stall carrying payload_byte with the flags
// first_of_packet, unit_start and last_of_packet. Configuration: cfg_valid /
// cfg_ready with cfg_index (0 target PID, 1 long packets, 2 section mode)
// and cfg_data; cfg_ready is always high, other indexes are ignored.
// Timing: a byte is held in the input register, is parsed by the packet
// state machine and lands in the output register, which drives the
// payload word on out_valid. One byte is taken per cycle while the
// output side keeps up; only receiver stalls slow the input down.
// Reset: the parser hunts for the first 0x47 and then counts packet
// offsets; target PID 0, 188-byte packets, section mode on.
// Stall: while the output word is held, the parser stops and the input
// register holds its byte, with in_stall high until out_stall drops.

`default_nettype none

module transport_stream_pid_filter_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [7:0]                     stream_byte,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [7:0]                          payload_byte,
	output logic                                first_of_packet,
	output logic                                unit_start,
	output logic                                last_of_packet,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [tspf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [tspf_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import tspf_pkg::*;

	cfg_t       cfg_q;
	logic       advance;
	logic       s1_valid;
	logic [7:0] byte_s1;
	result_t    res;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_pid   <= '0;
			cfg_q.long_packets <= 1'b0;
			cfg_q.section_mode <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TARGET_PID:   cfg_q.target_pid   <= cfg_data[PID_W-1:0];
				CFG_LONG_PACKETS: cfg_q.long_packets <= cfg_data[0];
				CFG_SECTION_MODE: cfg_q.section_mode <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	tspf_in_stage u_in (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.stream_byte (stream_byte),
		.advance     (advance),
		.s1_valid    (s1_valid),
		.byte_s1     (byte_s1)
	);

	tspf_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (s1_valid && advance),
		.byte_s1 (byte_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	tspf_out_stage u_out (
		.clk             (clk),
		.arst_n          (arst_n),
		.s1_valid        (s1_valid),
		.res             (res),
		.advance         (advance),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.payload_byte    (payload_byte),
		.first_of_packet (first_of_packet),
		.unit_start      (unit_start),
		.last_of_packet  (last_of_packet)
	);

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none

module tb_top;
	import tspf_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 6;
	localparam int MAX_REPORTS    = 10;
	localparam int ERROR_BIT      = 15;
	localparam int PUSI_BIT       = 14;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	// one payload word as the block should emit it
	typedef struct packed {
		logic [7:0] data;
		logic       is_first;
		logic       is_start;
		logic       is_last;
	} payload_word_t;

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   in_valid    = 1'b0;
	logic                   in_stall;
	logic [7:0]             stream_byte = 8'h00;
	logic                   out_valid;
	logic                   out_stall   = 1'b0;
	logic [7:0]             payload_byte;
	logic                   first_of_packet;
	logic                   unit_start;
	logic                   last_of_packet;
	logic                   cfg_valid   = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index   = '0;
	logic [CFG_DATA_W-1:0]  cfg_data    = '0;

	transport_stream_pid_filter_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.stream_byte    (stream_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.payload_byte   (payload_byte),
		.first_of_packet(first_of_packet),
		.unit_start     (unit_start),
		.last_of_packet (last_of_packet),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	logic [7:0]    stream_q [$];
	payload_word_t pending_payload [$];
	int            mismatches    = 0;
	int            send_idle_pct = 0;
	int            stall_pct     = 0;
	bit            hold_request  = 1'b0;
	int            hold_left     = 0;
	bit            in_fire       = 1'b0;

	// filter state and register copies, reset values
	logic          locked_q    = 1'b0;
	logic [7:0]    pos_q       = 8'd0;
	region_t       rgn_q       = RGN_HEADER;
	logic [7:0]    skip_q      = 8'd0;
	logic [15:0]   hdr_q       = 16'd0;
	logic          first_q     = 1'b0;
	logic [12:0]   cfg_pid     = 13'd0;
	logic          cfg_long    = 1'b0;
	logic          cfg_section = 1'b1;

	function automatic region_t after_adapt();
		return (hdr_q[PUSI_BIT] && cfg_section) ? RGN_POINTER : RGN_PAYLOAD;
	endfunction

	// advance the filter by one stream byte; returns 1 when a payload word results
	function automatic bit filter_byte(input logic [7:0] b, output payload_word_t w);
		logic [7:0] pos;
		logic [7:0] period;
		bit hit;
		hit = 1'b0;
		w = '0;
		if (!locked_q) begin
			if (b == SYNC_MARK) begin
				locked_q = 1'b1;
				rgn_q = RGN_HEADER;
				hdr_q = 16'd0;
				first_q = 1'b0;
				skip_q = 8'd0;
				pos_q = 8'd1;
			end
			return 1'b0;
		end
		pos = pos_q;
		period = cfg_long ? PKT_LEN_LONG : PKT_LEN;
		if (pos == 8'd0) begin
			hdr_q = 16'd0;
			first_q = 1'b0;
			skip_q = 8'd0;
			rgn_q = (b == SYNC_MARK) ? RGN_HEADER : RGN_DROP;
		end else if (pos < PKT_LEN) begin
			case (rgn_q)
				RGN_HEADER: begin
					if (pos == 8'd1) begin
						hdr_q = {b, 8'h00};
					end else if (pos == 8'd2) begin
						hdr_q[7:0] = b;
					end else if (pos == 8'd3) begin
						if (!hdr_q[ERROR_BIT] && b[PAYLOAD_FLAG_BIT] && hdr_q[12:0] == cfg_pid) begin
							first_q = 1'b1;
							rgn_q = b[ADAPT_FLAG_BIT] ? RGN_ADAPT_LEN : after_adapt();
						end else begin
							rgn_q = RGN_DROP;
						end
					end else begin
						rgn_q = RGN_DROP;
					end
				end
				RGN_ADAPT_LEN: begin
					skip_q = b;
					rgn_q = (b != 8'd0) ? RGN_ADAPT_SKIP : after_adapt();
				end
				RGN_ADAPT_SKIP: begin
					skip_q = skip_q - 8'd1;
					if (skip_q == 8'd0)
						rgn_q = after_adapt();
				end
				RGN_POINTER: begin
					skip_q = b;
					rgn_q = (b != 8'd0) ? RGN_POINTER_SKIP : RGN_PAYLOAD;
				end
				RGN_POINTER_SKIP: begin
					skip_q = skip_q - 8'd1;
					if (skip_q == 8'd0)
						rgn_q = RGN_PAYLOAD;
				end
				RGN_PAYLOAD: begin
					w.data = b;
					w.is_first = first_q;
					w.is_start = hdr_q[PUSI_BIT];
					w.is_last = (pos == LAST_OFFSET);
					first_q = 1'b0;
					hit = 1'b1;
				end
				default: begin
					rgn_q = RGN_DROP;
				end
			endcase
		end
		pos_q = (pos + 8'd1 >= period) ? 8'd0 : pos + 8'd1;
		return hit;
	endfunction

	function automatic void note_error(input string msg);
		if (mismatches < MAX_REPORTS)
			$display("%s", msg);
		mismatches++;
	endfunction

	// input acceptance feeds the predictor, output acceptance is checked
	always @(posedge clk) begin
		payload_word_t want;
		payload_word_t got;
		in_fire = arst_n && in_valid && !in_stall;
		if (in_fire && filter_byte(stream_byte, want))
			pending_payload.push_back(want);
		if (arst_n && out_valid && !out_stall) begin
			got = {payload_byte, first_of_packet, unit_start, last_of_packet};
			if (pending_payload.size() == 0) begin
				note_error($sformatf("unexpected word: byte %h first %b start %b last %b",
					got.data, got.is_first, got.is_start, got.is_last));
			end else begin
				want = pending_payload.pop_front();
				if (got != want)
					note_error($sformatf({"word mismatch: expected byte %h first %b start %b ",
						"last %b, got byte %h first %b start %b last %b"},
						want.data, want.is_first, want.is_start, want.is_last,
						got.data, got.is_first, got.is_start, got.is_last));
			end
		end
	end

	// byte driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				stream_byte <= stream_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_top NOT OK");
		$finish;
	end

	task automatic use_idle(input idle_mode_t m);
		case (m)
			IDLE_SENDER: begin
				send_idle_pct = 49;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				stall_pct = 49;
			end
			IDLE_BOTH: begin
				send_idle_pct = 10;
				stall_pct = 10;
			end
			default: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
		endcase
	endtask

	// leaves cfg_valid high; the caller lowers it after its last write
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_TARGET_PID:   cfg_pid = val[PID_W-1:0];
			CFG_LONG_PACKETS: cfg_long = val[0];
			CFG_SECTION_MODE: cfg_section = val[0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [12:0] pid, input bit lng, input bit sec);
		logic [31:0] rnd;
		rnd = $urandom;
		write_reg(CFG_TARGET_PID, pid);
		write_reg(CFG_LONG_PACKETS, {rnd[11:0], lng});
		write_reg(CFG_SECTION_MODE, {rnd[23:12], sec});
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (stream_q.size() != 0 || in_valid || pending_payload.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// pad the stream up to the next packet boundary
	task automatic align_stream();
		int period;
		int gap;
		period = int'(cfg_long ? PKT_LEN_LONG : PKT_LEN);
		gap = 0;
		if (locked_q && pos_q != 8'd0)
			gap = (int'(pos_q) >= period) ? 1 : period - int'(pos_q);
		repeat (gap) stream_q.push_back(8'($urandom_range(255)));
	endtask

	// one packet of the current period; keep cuts it short
	task automatic queue_packet(input bit sync_ok, input bit err, input bit pusi,
		input logic [12:0] pid, input bit adapt, input bit payl,
		input int alen, input int ptr, input int keep);
		logic [7:0] pkt [0:191];
		logic [31:0] rnd;
		int n;
		int at;
		n = int'(cfg_long ? PKT_LEN_LONG : PKT_LEN);
		if (keep > n)
			keep = n;
		rnd = $urandom;
		for (int i = 0; i < n; i++)
			pkt[i] = 8'($urandom_range(255));
		if (sync_ok) begin
			pkt[0] = SYNC_MARK;
		end else begin
			do pkt[0] = 8'($urandom_range(255)); while (pkt[0] == SYNC_MARK);
		end
		pkt[1] = {err, pusi, rnd[0], pid[12:8]};
		pkt[2] = pid[7:0];
		pkt[3] = {rnd[2:1], adapt, payl, rnd[6:3]};
		at = 4;
		if (adapt) begin
			pkt[4] = alen[7:0];
			at = 5 + alen;
		end
		if (pusi && cfg_section && at < PKT_LEN)
			pkt[at] = ptr[7:0];
		for (int i = 0; i < keep; i++)
			stream_q.push_back(pkt[i]);
	endtask

	// mostly short skips, some long, a few past the packet end
	function automatic int skip_length();
		int roll;
		roll = $urandom_range(99);
		if (roll < 70)
			return $urandom_range(24);
		if (roll < 90)
			return $urandom_range(183);
		return $urandom_range(255, 184);
	endfunction

	task automatic queue_random_packet(input int keep);
		logic [12:0] pid;
		int roll;
		bit sync_ok;
		bit err;
		bit pusi;
		bit adapt;
		bit payl;
		sync_ok = $urandom_range(99) >= 5;
		err = $urandom_range(99) < 8;
		payl = $urandom_range(99) >= 10;
		pusi = $urandom_range(99) < 40;
		adapt = $urandom_range(99) < 40;
		roll = $urandom_range(99);
		if (roll < 55)
			pid = cfg_pid;
		else if (roll < 70)
			pid = cfg_pid ^ (13'd1 << $urandom_range(12));
		else
			pid = 13'($urandom_range(8191));
		queue_packet(sync_ok, err, pusi, pid, adapt, payl, skip_length(), skip_length(), keep);
	endtask

	initial begin : stimulus
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings (PID 0, short packets, section mode), no idling
		use_idle(IDLE_NONE);
		// hunting: noise before the first sync
		stream_q.push_back(8'h00);
		stream_q.push_back(8'hFF);
		stream_q.push_back(8'h46);
		stream_q.push_back(8'h48);
		stream_q.push_back(8'hC7);
		// adaptation then pointer, runs to the last byte
		queue_packet(1'b1, 1'b0, 1'b1, 13'd0, 1'b1, 1'b1, 10, 5, 192);
		wait_drained();

		// long packets, no pointer skip; unused index is ignored
		use_idle(IDLE_SENDER);
		write_reg(CFG_UNUSED, 13'($urandom_range(8191)));
		set_config(13'h1FFF, 1'b1, 1'b0);
		align_stream();
		// stop in the trailing bytes
		queue_packet(1'b1, 1'b0, 1'b0, 13'h1FFF, 1'b1, 1'b1, 3, 0, 190);
		wait_drained();

		// period shrinks under the current offset
		use_idle(IDLE_RECEIVER);
		set_config(13'($urandom_range(8191)), 1'b0, 1'b1);
		align_stream();
		// receiver holds off while bytes keep coming
		hold_request = 1'b1;
		queue_packet(1'b1, 1'b0, 1'b1, cfg_pid, 1'b0, 1'b1, 0, 3, 192);
		wait_drained();

		// random settings and packet
		use_idle(IDLE_BOTH);
		set_config(13'($urandom_range(8191)), 1'($urandom_range(1)), 1'($urandom_range(1)));
		align_stream();
		queue_random_packet(192);
		// sender pauses until every word is out
		wait_drained();
		// lost sync drops the packet
		queue_packet(1'b0, 1'b0, 1'b0, cfg_pid, 1'b0, 1'b1, 0, 0, 40);

		wait_drained();
		if (mismatches == 0 && pending_payload.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
